// ===== rtl/core/fslm_pkg.sv =====
// fslm_pkg: shared constants, types and the Latin-1 fold function for the
// folded substring line matcher. No dependencies.
package fslm_pkg;

  localparam int NUM_CELLS      = 32;
  localparam int MAX_PATTERN    = 32;
  localparam int MAX_LINE_BYTES = 500;
  localparam int LINE_BYTES_W   = 10;
  localparam int LEN_W          = 6;
  localparam int LINE_NUM_W     = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int NUM_WORDS      = 4;
  localparam int BYTES_PER_WORD = 8;

  localparam logic [7:0] LINE_END = 8'd10;
  localparam logic [7:0] CASE_GAP = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LEN = 3'd0,
    CFG_WORD_0      = 3'd1,
    CFG_WORD_1      = 3'd2,
    CFG_WORD_2      = 3'd3,
    CFG_WORD_3      = 3'd4
  } cfg_idx_t;

  // per-cell pattern control
  typedef struct packed {
    logic       active;
    logic       last;
    logic [7:0] pat_byte;
  } cell_ctl_t;

  // per-byte step control shared by all cells
  typedef struct packed {
    logic advance;
    logic clear;
  } step_t;

  typedef struct packed {
    logic [LINE_NUM_W-1:0] line_number;
    logic                  overflow;
  } result_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    case (b)
      8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229: c = "a";
      8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197: c = "A";
      8'd232, 8'd233, 8'd234, 8'd235:                 c = "e";
      8'd200, 8'd201, 8'd202, 8'd203:                 c = "E";
      8'd236, 8'd237, 8'd238, 8'd239:                 c = "i";
      8'd204, 8'd205, 8'd206, 8'd207:                 c = "I";
      8'd242, 8'd243, 8'd244, 8'd246, 8'd248:         c = "o";
      8'd210, 8'd211, 8'd212, 8'd214, 8'd216:         c = "O";
      8'd249, 8'd250, 8'd251, 8'd252:                 c = "u";
      8'd217, 8'd218, 8'd219, 8'd220:                 c = "U";
      8'd255: c = "y";
      8'd199: c = "C";
      8'd231: c = "c";
      8'd163: c = "L";
      8'd159: c = "f";
      8'd241: c = "n";
      8'd209: c = "N";
      8'd208: c = "D";
      default: c = b;
    endcase
    if (c >= "A" && c <= "Z") begin
      c = c + CASE_GAP;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/fslm_in_if.sv =====
// fslm_in_if: valid/ready channel carrying one text byte per transaction.
// No dependencies.
interface fslm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== rtl/core/fslm_out_if.sv =====
// fslm_out_if: valid/ready channel carrying one line report per transaction.
// No dependencies.
interface fslm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_number;
  logic        overflow;

  modport source (output valid, output line_number, output overflow, input ready);
  modport sink   (input valid, input line_number, input overflow, output ready);
endinterface

// ===== rtl/core/folded_substring_line_matcher_core.sv =====
// Folded substring line matcher: case- and accent-insensitive search of a
// configured pattern (up to 32 bytes) over a Latin-1 byte stream; reports the
// number of each line containing the pattern when its newline arrives.
// Depends on fslm_pkg, fslm_in_if, fslm_out_if, fslm_cell, fslm_outq.
//
// One text byte is taken every cycle: a row of 32 match cells updates the
// whole partial-match vector in the cycle the byte is accepted, and a report
// goes into a two-entry output queue, so in_ch.ready drops only while both
// queue entries hold untaken reports. A line of 500 bytes or more before its
// newline yields one overflow report and the block then discards input until
// reset. Pattern registers are written through cfg_we/cfg_index/cfg_data and
// apply from the next byte; there is no startup delay after reset.
module folded_substring_line_matcher_core (
  input  logic                             clk,
  input  logic                             rst_n,
  fslm_in_if.sink                          in_ch,
  fslm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fslm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fslm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fslm_pkg::*;

  logic [LEN_W-1:0]        pattern_len_r;
  logic [CFG_DATA_W-1:0]   pat_words_r [NUM_WORDS];
  logic [LINE_NUM_W-1:0]   line_cnt_r, line_cnt_nxt;
  logic [LINE_BYTES_W-1:0] bytes_r, bytes_nxt;
  logic                    line_hit_r, line_hit_nxt;
  logic                    halted_r, halted_nxt;

  logic [LEN_W-1:0]        len_used;
  logic [7:0]              text_fold;
  cell_ctl_t               ctl [NUM_CELLS];
  step_t                   step;
  logic [NUM_CELLS-1:0]    bits;
  logic [NUM_CELLS-1:0]    hits;

  logic in_fire, live, over, ovf_event, proc, is_nl, hit_any, line_hit_now;
  logic push, q_full;
  result_t push_data;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        pat_words_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LEN: pattern_len_r  <= cfg_data[LEN_W-1:0];
        CFG_WORD_0:      pat_words_r[0] <= cfg_data;
        CFG_WORD_1:      pat_words_r[1] <= cfg_data;
        CFG_WORD_2:      pat_words_r[2] <= cfg_data;
        CFG_WORD_3:      pat_words_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_used = (pattern_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : pattern_len_r;

  // step control
  assign in_ch.ready  = !q_full;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign live         = in_fire & !halted_r;
  assign over         = (bytes_r >= LINE_BYTES_W'(MAX_LINE_BYTES));
  assign ovf_event    = live & over;
  assign proc         = live & !over;
  assign is_nl        = (in_ch.text_byte == LINE_END);
  assign text_fold    = fold_byte(in_ch.text_byte);
  assign step.advance = proc;
  assign step.clear   = is_nl;

  // match chain
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    logic prev;
    assign ctl[j].active   = (LEN_W'(j) < len_used);
    assign ctl[j].last     = (LEN_W'(j + 1) == len_used);
    assign ctl[j].pat_byte =
      pat_words_r[j / BYTES_PER_WORD][(j % BYTES_PER_WORD) * 8 +: 8];
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = bits[j-1];
    end
    fslm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[j]),
      .step      (step),
      .text_fold (text_fold),
      .prev_bit  (prev),
      .match_bit (bits[j]),
      .hit       (hits[j])
    );
  end

  assign hit_any      = |hits;
  assign line_hit_now = line_hit_r | hit_any;

  assign push                  = ovf_event | (proc & is_nl & line_hit_now);
  assign push_data.line_number = line_cnt_r;
  assign push_data.overflow    = ovf_event;

  // line state
  always_comb begin
    line_cnt_nxt = line_cnt_r;
    bytes_nxt    = bytes_r;
    line_hit_nxt = line_hit_r;
    halted_nxt   = halted_r | ovf_event;
    if (proc) begin
      if (is_nl) begin
        bytes_nxt    = '0;
        line_hit_nxt = 1'b0;
        if (line_cnt_r != '1) begin
          line_cnt_nxt = line_cnt_r + 1'b1;
        end
      end else begin
        bytes_nxt    = bytes_r + 1'b1;
        line_hit_nxt = line_hit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= LINE_NUM_W'(1);
      bytes_r    <= '0;
      line_hit_r <= 1'b0;
      halted_r   <= 1'b0;
    end else begin
      line_cnt_r <= line_cnt_nxt;
      bytes_r    <= bytes_nxt;
      line_hit_r <= line_hit_nxt;
      halted_r   <= halted_nxt;
    end
  end

  fslm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_ch    (out_ch)
  );

  // checks
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output");

  a_overflow_halts: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_event |=> halted_r)
    else $error("overflow did not halt");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt released without reset");

  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && is_nl) |=> (bytes_r == '0 && !line_hit_r && bits == '0))
    else $error("line state not cleared at newline");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r != '0)
    else $error("line counter wrapped to zero");

endmodule

// ===== rtl/core/fslm_cell.sv =====
// fslm_cell: one position of the shift-and match chain; holds one partial
// match bit and compares its folded pattern byte with the folded text byte.
// Depends on fslm_pkg.
module fslm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  fslm_pkg::cell_ctl_t ctl,
  input  fslm_pkg::step_t   step,
  input  logic [7:0]        text_fold,
  input  logic              prev_bit,
  output logic              match_bit,
  output logic              hit
);
  import fslm_pkg::*;

  logic bit_r;
  logic bit_nxt;
  logic match_now;

  assign match_now = prev_bit & ctl.active & (fold_byte(ctl.pat_byte) == text_fold);
  assign hit       = match_now & ctl.last;
  assign match_bit = bit_r;

  always_comb begin
    bit_nxt = bit_r;
    if (step.advance) begin
      bit_nxt = step.clear ? 1'b0 : match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

endmodule

// ===== rtl/core/fslm_outq.sv =====
// fslm_outq: two-entry result queue (output register plus skid entry) that
// decouples the matcher from the result channel. Depends on fslm_pkg, fslm_out_if.
module fslm_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fslm_pkg::result_t push_data,
  output logic              full,
  fslm_out_if.source        out_ch
);
  import fslm_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] occ;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign pop                = out_ch.valid & out_ch.ready;
  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.line_number = slot0_r.line_number;
  assign out_ch.overflow    = slot0_r.overflow;
  assign full               = (cnt_r == 2'd2);

  always_comb begin
    occ       = cnt_r - {1'b0, pop};
    slot0_nxt = pop ? slot1_r : slot0_r;
    slot1_nxt = slot1_r;
    if (push) begin
      if (occ == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
    end
    cnt_nxt = occ + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ===== tb/fslm_line_checker.sv =====
`timescale 1ns / 100ps
// fslm_line_checker: watches the text, report and register ports of the line matcher,
// predicts every line report and compares each received transaction with it.
// Depends on fslm_pkg.
module fslm_line_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [fslm_pkg::LINE_NUM_W-1:0]  out_line,
  input  logic                             out_ovf,
  input  logic                             cfg_we,
  input  logic [fslm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fslm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               open_reports
);
  import fslm_pkg::*;

  logic [LEN_W-1:0]      len_reg;
  logic [CFG_DATA_W-1:0] word_reg [NUM_WORDS];
  logic [31:0]           match_vec;
  logic [LINE_NUM_W-1:0] line_no;
  int                    line_len;
  logic                  hit_in_line;
  logic                  stopped;
  result_t               report_q [$];

  function automatic logic [7:0] fold_latin1(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197,
      8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229: c = "a";
      8'd200, 8'd201, 8'd202, 8'd203,
      8'd232, 8'd233, 8'd234, 8'd235:                 c = "e";
      8'd204, 8'd205, 8'd206, 8'd207,
      8'd236, 8'd237, 8'd238, 8'd239:                 c = "i";
      8'd210, 8'd211, 8'd212, 8'd214, 8'd216,
      8'd242, 8'd243, 8'd244, 8'd246, 8'd248:         c = "o";
      8'd217, 8'd218, 8'd219, 8'd220,
      8'd249, 8'd250, 8'd251, 8'd252:                 c = "u";
      8'd255:         c = "y";
      8'd199, 8'd231: c = "c";
      8'd163:         c = "l";
      8'd159:         c = "f";
      8'd209, 8'd241: c = "n";
      8'd208:         c = "d";
      default:        c = b;
    endcase
    if (c >= "A" && c <= "Z") begin
      c = c + CASE_GAP;
    end
    return c;
  endfunction

  function automatic int used_len();
    int n;
    n = int'(len_reg);
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (n > 32) n = 32;
    return n;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int          n;
    logic [7:0]  f;
    logic [7:0]  p;
    logic [31:0] eq;
    result_t     r;
    if (stopped) return;
    if (line_len >= MAX_LINE_BYTES) begin
      stopped = 1'b1;
      r.line_number = line_no;
      r.overflow = 1'b1;
      report_q.push_back(r);
      return;
    end
    line_len++;
    n = used_len();
    f = fold_latin1(b);
    eq = '0;
    for (int j = 0; j < n; j++) begin
      p = word_reg[j / BYTES_PER_WORD][(j % BYTES_PER_WORD) * 8 +: 8];
      if (fold_latin1(p) == f) eq[j] = 1'b1;
    end
    match_vec = ((match_vec << 1) | 32'd1) & eq;
    if (n > 0 && match_vec[n-1]) hit_in_line = 1'b1;
    if (b == LINE_END) begin
      if (hit_in_line) begin
        r.line_number = line_no;
        r.overflow = 1'b0;
        report_q.push_back(r);
      end
      if (line_no != '1) line_no++;
      match_vec = '0;
      line_len = 0;
      hit_in_line = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    result_t r;
    if (!rst_n) begin
      len_reg = '0;
      for (int k = 0; k < NUM_WORDS; k++) word_reg[k] = '0;
      match_vec = '0;
      line_no = 1;
      line_len = 0;
      hit_in_line = 1'b0;
      stopped = 1'b0;
      report_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_LEN: len_reg = cfg_data[LEN_W-1:0];
          CFG_WORD_0:      word_reg[0] = cfg_data;
          CFG_WORD_1:      word_reg[1] = cfg_data;
          CFG_WORD_2:      word_reg[2] = cfg_data;
          CFG_WORD_3:      word_reg[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_byte(in_byte);
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report: line %0d overflow %0b", $time, out_line, out_ovf);
          fail_count++;
        end else begin
          r = report_q.pop_front();
          if (out_line !== r.line_number) begin
            $display("%0t: line_number expected %0d actual %0d", $time, r.line_number,
                     out_line);
            fail_count++;
          end
          if (out_ovf !== r.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, r.overflow, out_ovf);
            fail_count++;
          end
        end
      end
    end
    open_reports = report_q.size();
  end

endmodule

// ===== tb/tb_folded_substring_line_matcher_core.sv =====
`timescale 1ns / 100ps
// tb_folded_substring_line_matcher_core: drives text bytes, pattern registers and
// report back-pressure into the line matcher; fslm_line_checker judges the reports.
// Depends on fslm_pkg, fslm_in_if, fslm_out_if, fslm_line_checker and the core.
module tb_folded_substring_line_matcher_core;
  import fslm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    open_reports;
  int                    sent;
  bit                    calm;
  bit                    narrow;
  logic [7:0]            pat_base [32];
  int                    pat_used;

  fslm_in_if  in_ch ();
  fslm_out_if out_ch ();

  folded_substring_line_matcher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fslm_line_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_byte      (in_ch.text_byte),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_line     (out_ch.line_number),
    .out_ovf      (out_ch.overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_reports (open_reports)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  // random spelling that folds to the same letter
  function automatic logic [7:0] spell(input logic [7:0] c);
    int r;
    r = $urandom_range(0, 13);
    case (c)
      "a": return (r == 0) ? "a" : (r == 1) ? "A" : (r < 8) ? 8'(224 + r - 2) : 8'(192 + r - 8);
      "e": return (r % 10 == 0) ? "e" : (r % 10 == 1) ? "E" :
                  (r % 10 < 6) ? 8'(232 + r % 10 - 2) : 8'(200 + r % 10 - 6);
      "i": return (r % 10 == 0) ? "i" : (r % 10 == 1) ? "I" :
                  (r % 10 < 6) ? 8'(236 + r % 10 - 2) : 8'(204 + r % 10 - 6);
      "u": return (r % 10 == 0) ? "u" : (r % 10 == 1) ? "U" :
                  (r % 10 < 6) ? 8'(249 + r % 10 - 2) : 8'(217 + r % 10 - 6);
      "o": begin
        case (r % 12)
          0: return "o";
          1: return "O";
          2: return 8'd242;
          3: return 8'd243;
          4: return 8'd244;
          5: return 8'd246;
          6: return 8'd248;
          7: return 8'd210;
          8: return 8'd211;
          9: return 8'd212;
          10: return 8'd214;
          default: return 8'd216;
        endcase
      end
      "y": return (r % 3 == 0) ? "y" : (r % 3 == 1) ? "Y" : 8'd255;
      "c": return (r % 4 == 0) ? "c" : (r % 4 == 1) ? "C" : (r % 4 == 2) ? 8'd199 : 8'd231;
      "l": return (r % 3 == 0) ? "l" : (r % 3 == 1) ? "L" : 8'd163;
      "f": return (r % 3 == 0) ? "f" : (r % 3 == 1) ? "F" : 8'd159;
      "n": return (r % 4 == 0) ? "n" : (r % 4 == 1) ? "N" : (r % 4 == 2) ? 8'd241 : 8'd209;
      "d": return (r % 3 == 0) ? "d" : (r % 3 == 1) ? "D" : 8'd208;
      default: begin
        if (c >= "a" && c <= "z" && r[0]) return c - CASE_GAP;
        return c;
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_base();
    if (narrow) return $urandom_range(1) ? "a" : "b";
    case ($urandom_range(0, 14))
      0: return "a";
      1: return "e";
      2: return "i";
      3: return "o";
      4: return "u";
      5: return "y";
      6: return "c";
      7: return "n";
      8: return "l";
      9: return "d";
      10: return "f";
      11: return "x";
      12: return "z";
      13: return "0";
      default: return "-";
    endcase
  endfunction

  // never a newline: line ends are placed explicitly
  function automatic logic [7:0] filler();
    logic [7:0] b;
    if ($urandom_range(99) < (narrow ? 80 : 50)) b = spell(pick_base());
    else b = 8'($urandom_range(255));
    return (b == LINE_END) ? 8'd11 : b;
  endfunction

  task automatic send_char(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    while (open_reports != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_pattern(input logic [LEN_W-1:0] len_val);
    logic [CFG_DATA_W-1:0] w;
    int j;
    pat_used = (len_val > 32) ? 32 : int'(len_val);
    for (int k = 0; k < 32; k++) pat_base[k] = pick_base();
    for (int k = 0; k < NUM_WORDS; k++) begin
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
        j = k * BYTES_PER_WORD + b;
        w[b*8 +: 8] = (j < pat_used) ? spell(pat_base[j]) : 8'($urandom_range(255));
      end
      cfg_write(CFG_IDX_W'(CFG_WORD_0 + k), w);
    end
    cfg_write(CFG_PATTERN_LEN, {$urandom, 26'($urandom), len_val});
    cfg_we <= 1'b0;
  endtask

  task automatic send_pattern(input int n);
    for (int j = 0; j < n; j++) send_char(spell(pat_base[j]));
  endtask

  task automatic send_line(input int body, input bit terminate);
    int a;
    int kind;
    int ins;
    ins = (pat_used > 0) ? pat_used : 4;
    a = $urandom_range(0, body);
    kind = $urandom_range(99);
    repeat (a) send_char(filler());
    if (kind < 55) send_pattern(ins);
    else if (kind < 75) send_pattern(ins - 1);
    repeat (body - a) send_char(filler());
    if (terminate) send_char(LINE_END);
  endtask

  function automatic int body_len();
    return ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
  endfunction

  initial begin
    int ph;
    int start;
    int target;
    int r;
    logic [LEN_W-1:0] lv;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PATTERN_LEN;
    cfg_data = '0;
    rst_n = 1'b0;
    calm = 1'b0;
    narrow = 1'b0;
    sent = 0;
    pat_used = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero pattern length after reset: nothing matches
    send_char(8'h00);
    send_char("a");
    send_char(8'hFF);
    send_char(LINE_END);
    drain_reports();

    // pattern: zero byte, pound sign, 159, A-umlaut
    cfg_write(CFG_PATTERN_LEN, 64'd4);
    cfg_write(CFG_WORD_0, {$urandom, 32'hC49FA300});
    cfg_write(CFG_WORD_1, {$urandom, $urandom});
    cfg_write(CFG_WORD_2, {$urandom, $urandom});
    cfg_write(CFG_WORD_3, {$urandom, $urandom});
    cfg_we <= 1'b0;
    send_char("Z");
    send_char(8'h00);
    send_char("l");
    send_char("F");
    send_char("a");
    send_char(LINE_END);
    send_char("z");
    send_char(8'h00);
    send_char(8'hA3);
    send_char(8'h9F);
    send_char(LINE_END);
    send_char(LINE_END);
    // length change mid-line keeps the partial match
    send_char(8'h00);
    send_char("L");
    drain_reports();
    cfg_write(CFG_PATTERN_LEN, 64'd3);
    cfg_we <= 1'b0;
    send_char("f");
    send_char(LINE_END);

    ph = 0;
    while (sent < 720) begin
      r = $urandom_range(99);
      case (ph)
        0: lv = 6'd32;
        1: lv = 6'd63;
        2: lv = 6'd1;
        3: lv = 6'd0;
        default: begin
          if (r < 60) lv = 6'($urandom_range(1, 6));
          else if (r < 80) lv = 6'($urandom_range(7, 32));
          else if (r < 90) lv = 6'($urandom_range(33, 63));
          else lv = 6'd0;
        end
      endcase
      drain_reports();
      calm = 1'b0;
      narrow = (ph >= 4) && ($urandom_range(99) < 40);
      program_pattern(lv);
      calm = (ph == 4 || ph == 5);
      target = $urandom_range(60, 140);
      start = sent;
      while (sent - start < target) send_line(body_len(), 1'b1);
      if ($urandom_range(1)) send_line($urandom_range(0, 6), 1'b0);
      ph++;
    end

    // longest legal line, then one byte too many
    drain_reports();
    calm = 1'b0;
    narrow = 1'b0;
    program_pattern(6'd5);
    send_char(LINE_END);
    repeat (MAX_LINE_BYTES - 6) send_char(filler());
    send_pattern(5);
    send_char(LINE_END);
    repeat (200) send_char(filler());
    send_pattern(5);
    repeat (MAX_LINE_BYTES - 205) send_char(filler());
    send_char(LINE_END);
    // halted: ignored
    send_pattern(5);
    send_char(LINE_END);
    drain_reports();
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("tb_folded_substring_line_matcher_core OK");
    end else begin
      $display("tb_folded_substring_line_matcher_core NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("tb_folded_substring_line_matcher_core NOT OK");
    $finish;
  end

endmodule
